// File: hw/rtl/date_ordered_appointment_queue_defines.svh
// Assertion macros used by the appointment queue top module.
`ifndef DATE_ORDERED_APPOINTMENT_QUEUE_DEFINES_SVH
`define DATE_ORDERED_APPOINTMENT_QUEUE_DEFINES_SVH
`define DOAQ_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DOAQ_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/doaq_pkg.sv
// Types and constants of the appointment queue.
`default_nettype none
package doaq_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;
   localparam logic [1:0] CMD_FIND   = 2'd3;
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_DUPLICATE = 3'd4;
   localparam logic [2:0] ST_WINDOW    = 3'd5;
   localparam logic CSR_WIN_START = 1'b0;
   localparam logic CSR_WIN_END   = 1'b1;
   localparam logic [4:0] WIN_START_RESET = 5'd9;
   localparam logic [4:0] WIN_END_RESET   = 5'd22;
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [15:0] patient;
   } booking_type;
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SCAN_WAIT, S_SHIFT_RD, S_SHIFT_WR, S_DONE
   } state_type;
   function automatic logic key_after(booking_type a, booking_type b);
      return a[43:16] > b[43:16];
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/doaq_mem.sv
// Synchronous booking memory with one write and one registered read port.
`default_nettype none
module doaq_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [AW-1:0]         wr_addr,
   input  doaq_pkg::booking_type wr_data,
   input  wire [AW-1:0]         rd_addr,
   output doaq_pkg::booking_type rd_data
);
   doaq_pkg::booking_type mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/date_ordered_appointment_queue.sv
// Top level of the date-ordered appointment queue.
// Each command scans the held entries one memory read per cycle; pop reads only the first
// and cancel or find stop at a patient match. An accepted insert, pop or cancel then moves
// entries one at a time, read then written back; one command is worked at a time.
// The result strobe rsp_valid is high for one cycle; the receiver cannot stall it.
// Synchronous reset empties the queue and loads the window registers with 9 and 22.
`default_nettype none
`include "date_ordered_appointment_queue_defines.svh"
module date_ordered_appointment_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire [1:0]  req_cmd,
   input  wire [13:0] req_year,
   input  wire [3:0]  req_month,
   input  wire [4:0]  req_day,
   input  wire [4:0]  req_hour,
   input  wire [15:0] req_patient_id,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [13:0] rsp_out_year,
   output logic [3:0] rsp_out_month,
   output logic [4:0] rsp_out_day,
   output logic [4:0] rsp_out_hour,
   output logic [15:0] rsp_out_patient,
   output logic [6:0] rsp_entry_count,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_index,
   input  wire [4:0]  csr_data
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   doaq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, pos_ff, pos_in, dup_ff, dup_in;
   logic found_ff, found_in, gfound_ff, gfound_in;
   logic [4:0] ws_ff, we_ff;
   doaq_pkg::booking_type nb_ff, nb_in, got_ff, got_in;
   logic [1:0] cmd_ff, cmd_in;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   doaq_pkg::booking_type wr_data, rd_data;
   logic [2:0] st_ff, st_in;
   logic [CW-1:0] one;

   assign one = CW'(1);

   doaq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= doaq_pkg::WIN_START_RESET;
         we_ff <= doaq_pkg::WIN_END_RESET;
      end else if (csr_valid) begin
         if (csr_index == doaq_pkg::CSR_WIN_START) begin
            ws_ff <= csr_data;
         end else begin
            we_ff <= csr_data;
         end
      end
   end

   // idx_ff is the address read; a read result for idx_ff-1 appears in S_SCAN_WAIT.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      dup_in = dup_ff;
      found_in = found_ff;
      gfound_in = gfound_ff;
      nb_in = nb_ff;
      got_in = got_ff;
      cmd_in = cmd_ff;
      st_in = st_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = nb_ff;
      rd_addr = idx_ff[AW-1:0];
      busy = (state_ff != doaq_pkg::S_IDLE);
      unique case (state_ff)
         doaq_pkg::S_IDLE: begin
            if (start) begin
               nb_in = {req_year, req_month, req_day, req_hour, req_patient_id};
               cmd_in = req_cmd;
               idx_in = '0;
               pos_in = count_ff;
               dup_in = count_ff;
               found_in = 1'b0;
               gfound_in = 1'b0;
               state_in = doaq_pkg::S_SCAN;
            end
         end
         doaq_pkg::S_SCAN: begin
            if (idx_ff >= count_ff) begin
               state_in = doaq_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + one;
               state_in = doaq_pkg::S_SCAN_WAIT;
            end
         end
         doaq_pkg::S_SCAN_WAIT: begin
            if (!found_in && rd_data.patient == nb_ff.patient) begin
               found_in = 1'b1;
               dup_in = idx_ff - one;
               if (!gfound_ff) got_in = rd_data;
            end
            if (!gfound_ff && idx_ff == one) got_in = rd_data;
            if (!gfound_ff && doaq_pkg::key_after(rd_data, nb_ff)) begin
               gfound_in = 1'b1;
               pos_in = idx_ff - one;
            end
            if (cmd_ff == doaq_pkg::CMD_POP) begin
               got_in = (idx_ff == one) ? rd_data : got_ff;
            end else if (cmd_ff != doaq_pkg::CMD_INSERT) begin
               got_in = (found_ff) ? got_ff : rd_data;
            end
            if (idx_ff >= count_ff || (cmd_ff == doaq_pkg::CMD_POP)) begin
               state_in = doaq_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + one;
               rd_addr = idx_ff[AW-1:0];
               state_in = doaq_pkg::S_SCAN_WAIT;
            end
            if (found_in && cmd_ff != doaq_pkg::CMD_INSERT) state_in = doaq_pkg::S_DONE;
         end
         doaq_pkg::S_DONE: begin
            st_in = doaq_pkg::ST_OK;
            state_in = doaq_pkg::S_IDLE;
            unique case (cmd_ff)
               doaq_pkg::CMD_INSERT: begin
                  if (count_ff == FULL) st_in = doaq_pkg::ST_FULL;
                  else if (found_ff) st_in = doaq_pkg::ST_DUPLICATE;
                  else if (nb_ff.hour < ws_ff || nb_ff.hour > we_ff)
                     st_in = doaq_pkg::ST_WINDOW;
                  if (st_in == doaq_pkg::ST_OK) begin
                     idx_in = count_ff;
                     state_in = doaq_pkg::S_SHIFT_RD;
                  end
               end
               doaq_pkg::CMD_POP: begin
                  if (count_ff == '0) st_in = doaq_pkg::ST_EMPTY;
                  else begin
                     idx_in = '0;
                     state_in = doaq_pkg::S_SHIFT_RD;
                  end
               end
               doaq_pkg::CMD_CANCEL: begin
                  if (!found_ff) st_in = doaq_pkg::ST_NOT_FOUND;
                  else begin
                     idx_in = dup_ff;
                     state_in = doaq_pkg::S_SHIFT_RD;
                  end
               end
               default: begin
                  if (!found_ff) st_in = doaq_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         doaq_pkg::S_SHIFT_RD: begin
            // Insert moves entries up from the top; removals move them down.
            if (cmd_ff == doaq_pkg::CMD_INSERT) begin
               if (idx_ff == pos_ff) begin
                  wr_en = 1'b1;
                  wr_data = nb_ff;
                  count_in = count_ff + one;
                  state_in = doaq_pkg::S_IDLE;
               end else begin
                  rd_addr = AW'(idx_ff - one);
                  state_in = doaq_pkg::S_SHIFT_WR;
               end
            end else begin
               if (idx_ff + one >= count_ff) begin
                  count_in = count_ff - one;
                  state_in = doaq_pkg::S_IDLE;
               end else begin
                  rd_addr = AW'(idx_ff + one);
                  state_in = doaq_pkg::S_SHIFT_WR;
               end
            end
         end
         doaq_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            idx_in = (cmd_ff == doaq_pkg::CMD_INSERT) ? idx_ff - one : idx_ff + one;
            state_in = doaq_pkg::S_SHIFT_RD;
         end
         default: state_in = doaq_pkg::S_IDLE;
      endcase
   end

   logic resp_in, resp_ff;
   always_comb begin
      resp_in = 1'b0;
      if (state_ff == doaq_pkg::S_DONE && state_in == doaq_pkg::S_IDLE) resp_in = 1'b1;
      if (state_ff == doaq_pkg::S_SHIFT_RD && state_in == doaq_pkg::S_IDLE) resp_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= doaq_pkg::S_IDLE;
         count_ff <= '0;
         resp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         resp_ff <= resp_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      dup_ff <= dup_in;
      found_ff <= found_in;
      gfound_ff <= gfound_in;
      nb_ff <= nb_in;
      got_ff <= got_in;
      cmd_ff <= cmd_in;
      st_ff <= st_in;
   end

   doaq_pkg::booking_type shown;
   always_comb begin
      shown = '0;
      if (st_ff == doaq_pkg::ST_OK) begin
         shown = (cmd_ff == doaq_pkg::CMD_INSERT) ? nb_ff : got_ff;
      end
   end
   assign rsp_valid = resp_ff;
   assign rsp_status = st_ff;
   assign rsp_out_year = shown.year;
   assign rsp_out_month = shown.month;
   assign rsp_out_day = shown.day;
   assign rsp_out_hour = shown.hour;
   assign rsp_out_patient = shown.patient;
   assign rsp_entry_count = 7'(count_ff);

   `DOAQ_ASSERT_IMPL(a_count_bound, clock, reset, (count_ff <= FULL), "count above depth")
   `DOAQ_ASSERT_IMPL(a_resp_idle, clock, reset, (rsp_valid |-> !busy), "result while busy")
   `DOAQ_ASSERT_IMPL(a_count_hold, clock, reset, (!busy |=> $stable(count_ff)), "count moved idle")
   `DOAQ_ASSERT_NORST(a_reset_idle, clock, (reset |=> !busy), "busy after reset")
endmodule
`default_nettype wire
